FILE: hw/rtl/gpmls_pkg.sv
// Package: types, byte codes and tables for the gamepad poll sequencer.
package gpmls_pkg;

  localparam int unsigned ByteW    = 8;
  localparam int unsigned PosW     = 5;
  localparam int unsigned ModeW    = 2;
  localparam int unsigned IdW      = 4;
  localparam int unsigned CfgIdxW  = 2;
  localparam int unsigned CfgDataW = 5;
  localparam int unsigned TailIdxW = 3;

  localparam logic [ByteW-1:0] ByteStart = 8'h01;
  localparam logic [ByteW-1:0] ByteZero  = 8'h00;
  localparam logic [ByteW-1:0] ByteAck   = 8'h5A;
  localparam logic [ByteW-1:0] CmdPoll   = 8'h42;
  localparam logic [ByteW-1:0] CmdSetup  = 8'h43;
  localparam logic [ByteW-1:0] CmdConfig = 8'h44;
  localparam logic [ByteW-1:0] ByteLockA = 8'h03;

  localparam logic [PosW-1:0]  MaxPayloadRst = 5'd6;
  localparam logic [IdW-1:0]   AnalogIdRst   = 4'd7;

  typedef enum logic [ModeW-1:0] {
    MODE_RUN    = 2'd0,
    MODE_SETUP  = 2'd1,
    MODE_CONFIG = 2'd2,
    MODE_EXIT   = 2'd3
  } mode_e;

  typedef enum logic [1:0] {
    STG_CMD  = 2'd0,
    STG_ID   = 2'd1,
    STG_ACK  = 2'd2,
    STG_BODY = 2'd3
  } stage_e;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_MAX_PAYLOAD = 2'd0,
    CFG_ANALOG_ID   = 2'd1
  } cfg_idx_e;

  // Command byte sent second in each poll.
  function automatic logic [ByteW-1:0] cmd_byte(mode_e m);
    logic [ByteW-1:0] b;
    case (m)
      MODE_RUN:    b = CmdPoll;
      MODE_SETUP:  b = CmdSetup;
      MODE_CONFIG: b = CmdConfig;
      MODE_EXIT:   b = CmdSetup;
      default:     b = CmdPoll;
    endcase
    return b;
  endfunction

  // Number of tail bytes sent after the acknowledge in the setup modes.
  function automatic logic [TailIdxW-1:0] tail_len(mode_e m);
    logic [TailIdxW-1:0] n;
    case (m)
      MODE_SETUP:  n = 3'd2;
      MODE_CONFIG: n = 3'd6;
      MODE_EXIT:   n = 3'd6;
      default:     n = 3'd0;
    endcase
    return n;
  endfunction

  // Tail byte at a given position.
  function automatic logic [ByteW-1:0] tail_byte(mode_e m, logic [TailIdxW-1:0] idx);
    logic [ByteW-1:0] b;
    b = ByteZero;
    case (m)
      MODE_SETUP: begin
        if (idx == 3'd0) b = ByteStart;
      end
      MODE_CONFIG: begin
        if (idx == 3'd0) b = ByteStart;
        else if (idx == 3'd1) b = ByteLockA;
      end
      default: b = ByteZero;
    endcase
    return b;
  endfunction

endpackage

FILE: hw/rtl/gamepad_poll_and_mode_lock_sequencer.sv
// Top level: gamepad poll sequencer with analog mode lock.
//
// Usage: each input transaction is either a start-poll request (action 0) or
// the byte received in the exchange just finished (action 1). Each accepted
// input yields exactly one result transaction: the next byte to shift out
// (send 1) or the end of the poll (send 0), plus any payload byte and the
// current link mode.
// Output: a result is registered and appears in the cycle after its input is
// accepted, held in the output register until taken.
// Throughput: one transaction per cycle; the only limit is the output
// register, which frees itself in the same cycle the receiver takes it.
// Stall: while the output register is full and out_ready_i is low, in_ready_o
// drops and the state holds; nothing is lost or repeated.
// Reset: link mode running, no poll active, max_payload 6, analog_id 7,
// output register empty.
// Configuration: cfg_ready_o is always high; write only while idle.
module gamepad_poll_and_mode_lock_sequencer (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             in_valid_i,
  output logic                             in_ready_o,
  input  logic                             action_i,
  input  logic [7:0]                       rx_byte_i,
  output logic                             out_valid_o,
  input  logic                             out_ready_i,
  output logic [7:0]                       tx_byte_o,
  output logic                             send_o,
  output logic                             data_valid_o,
  output logic [4:0]                       data_index_o,
  output logic [7:0]                       data_byte_o,
  output logic [1:0]                       mode_now_o,
  input  logic                             cfg_valid_i,
  output logic                             cfg_ready_o,
  input  logic [gpmls_pkg::CfgIdxW-1:0]    cfg_index_i,
  input  logic [gpmls_pkg::CfgDataW-1:0]   cfg_data_i
);
  import gpmls_pkg::*;

  // Configuration registers
  logic [PosW-1:0] max_payload_q;
  logic [IdW-1:0]  analog_id_q;

  // Sequencer state
  mode_e           link_mode_q, link_mode_d;
  mode_e           poll_mode_q, poll_mode_d;
  stage_e          stage_q, stage_d;
  logic            active_q, active_d;
  logic [PosW-1:0] pos_q, pos_d;
  logic [PosW-1:0] count_q, count_d;

  // Result register
  logic             out_valid_q;
  logic [ByteW-1:0] tx_q, tx_d;
  logic             send_q, send_d;
  logic             dv_q, dv_d;
  logic [PosW-1:0]  di_q, di_d;
  logic [ByteW-1:0] db_q, db_d;

  logic             accept;
  logic [PosW-1:0]  id_len;
  logic [PosW:0]    pos_inc;
  logic [TailIdxW-1:0] tail_idx;

  assign cfg_ready_o = 1'b1;
  // Take a new transaction whenever the result slot is empty or draining.
  assign in_ready_o  = !out_valid_q || out_ready_i;
  assign accept      = in_valid_i && in_ready_o;

  // Payload length from the ID low nibble, capped by max_payload.
  always_comb begin
    logic [PosW-1:0] dbl;
    dbl    = {rx_byte_i[3:0], 1'b0};
    id_len = (dbl > max_payload_q) ? max_payload_q : dbl;
  end

  assign pos_inc  = {1'b0, pos_q} + {{PosW{1'b0}}, 1'b1};
  assign tail_idx = pos_inc[TailIdxW-1:0];

  always_comb begin
    link_mode_d = link_mode_q;
    poll_mode_d = poll_mode_q;
    stage_d     = stage_q;
    active_d    = active_q;
    pos_d       = pos_q;
    count_d     = count_q;
    tx_d        = ByteZero;
    send_d      = 1'b0;
    dv_d        = 1'b0;
    di_d        = '0;
    db_d        = ByteZero;

    if (!action_i) begin
      // Start a poll; latch the mode for its whole length.
      poll_mode_d = link_mode_q;
      stage_d     = STG_CMD;
      pos_d       = '0;
      active_d    = 1'b1;
      tx_d        = ByteStart;
      send_d      = 1'b1;
    end else if (active_q) begin
      case (stage_q)
        STG_CMD: begin
          tx_d    = cmd_byte(poll_mode_q);
          send_d  = 1'b1;
          stage_d = STG_ID;
        end
        STG_ID: begin
          count_d = id_len;
          // Pad not in analog mode: drop into setup right away.
          if (poll_mode_q == MODE_RUN && rx_byte_i[7:4] != analog_id_q) begin
            link_mode_d = MODE_SETUP;
          end
          send_d  = 1'b1;
          stage_d = STG_ACK;
        end
        STG_ACK: begin
          pos_d = '0;
          if (rx_byte_i != ByteAck) begin
            active_d = 1'b0;
          end else if (poll_mode_q == MODE_RUN) begin
            if (count_q == '0) begin
              active_d = 1'b0;
            end else begin
              send_d  = 1'b1;
              stage_d = STG_BODY;
            end
          end else begin
            // Advance the lock sequence and start the tail.
            link_mode_d = mode_e'(poll_mode_q + 2'd1);
            tx_d        = tail_byte(poll_mode_q, '0);
            send_d      = 1'b1;
            stage_d     = STG_BODY;
          end
        end
        STG_BODY: begin
          if (poll_mode_q == MODE_RUN) begin
            dv_d = 1'b1;
            di_d = pos_q;
            db_d = (pos_q < 5'd2) ? ~rx_byte_i : rx_byte_i;
            if (pos_inc < {1'b0, count_q}) begin
              send_d = 1'b1;
              pos_d  = pos_inc[PosW-1:0];
            end else begin
              active_d = 1'b0;
            end
          end else begin
            if (pos_inc < {{(PosW+1-TailIdxW){1'b0}}, tail_len(poll_mode_q)}) begin
              tx_d   = tail_byte(poll_mode_q, tail_idx);
              send_d = 1'b1;
              pos_d  = pos_inc[PosW-1:0];
            end else begin
              active_d = 1'b0;
            end
          end
        end
        default: begin
          active_d = 1'b0;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_payload_q <= MaxPayloadRst;
      analog_id_q   <= AnalogIdRst;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        CFG_MAX_PAYLOAD: max_payload_q <= cfg_data_i[PosW-1:0];
        CFG_ANALOG_ID:   analog_id_q   <= cfg_data_i[IdW-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      link_mode_q <= MODE_RUN;
      poll_mode_q <= MODE_RUN;
      stage_q     <= STG_CMD;
      active_q    <= 1'b0;
      pos_q       <= '0;
      count_q     <= '0;
    end else if (accept) begin
      link_mode_q <= link_mode_d;
      poll_mode_q <= poll_mode_d;
      stage_q     <= stage_d;
      active_q    <= active_d;
      pos_q       <= pos_d;
      count_q     <= count_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (accept) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  // Result payload: load on accept, hold otherwise.
  always_ff @(posedge clk_i) begin
    if (accept) begin
      tx_q <= tx_d;
      send_q <= send_d;
      dv_q <= dv_d;
      di_q <= di_d;
      db_q <= db_d;
    end
  end

  logic [ModeW-1:0] mode_q;
  always_ff @(posedge clk_i) begin
    if (accept) begin
      mode_q <= link_mode_d;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign tx_byte_o    = tx_q;
  assign send_o       = send_q;
  assign data_valid_o = dv_q;
  assign data_index_o = di_q;
  assign data_byte_o  = db_q;
  assign mode_now_o   = mode_q;

endmodule

FILE: tb/poll_exchange_checker.sv
// Poll exchange checker: predicts each sequencer result and compares it with the block.
module poll_exchange_checker
  import gpmls_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  input  logic                in_ready_i,
  input  logic                action_i,
  input  logic [ByteW-1:0]    rx_byte_i,
  input  logic                out_valid_i,
  input  logic                out_ready_i,
  input  logic [ByteW-1:0]    tx_byte_i,
  input  logic                send_i,
  input  logic                data_valid_i,
  input  logic [PosW-1:0]     data_index_i,
  input  logic [ByteW-1:0]    data_byte_i,
  input  logic [ModeW-1:0]    mode_now_i,
  input  logic                cfg_valid_i,
  input  logic                cfg_ready_i,
  input  logic [CfgIdxW-1:0]  cfg_index_i,
  input  logic [CfgDataW-1:0] cfg_data_i,
  output int unsigned         fail_count_o,
  output int unsigned         pending_o
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic [ByteW-1:0] tx;
    logic             send;
    logic             dv;
    logic [PosW-1:0]  idx;
    logic [ByteW-1:0] data;
    mode_e            mode;
  } poll_result_t;

  poll_result_t     expected_results[$];
  int unsigned      mismatches = 0;

  // Sequencer state and registers as the predictor sees them.
  mode_e            link_mode;
  mode_e            poll_mode;
  stage_e           stage;
  logic [PosW-1:0]  body_pos;
  logic [PosW-1:0]  payload_len;
  logic [PosW-1:0]  max_payload;
  logic [IdW-1:0]   analog_id;
  logic             active;

  assign fail_count_o = mismatches;

  function automatic logic [ByteW-1:0] lock_cmd(mode_e m);
    case (m)
      MODE_SETUP:  return CmdSetup;
      MODE_CONFIG: return CmdConfig;
      MODE_EXIT:   return CmdSetup;
      default:     return CmdPoll;
    endcase
  endfunction

  function automatic int lock_tail_len(mode_e m);
    case (m)
      MODE_SETUP:  return 2;
      MODE_CONFIG: return 6;
      MODE_EXIT:   return 6;
      default:     return 0;
    endcase
  endfunction

  // Setup sends 01 00, configuring 01 03 00 00 00 00, exit setup all zero.
  function automatic logic [ByteW-1:0] lock_tail(mode_e m, int pos);
    if ((m == MODE_SETUP || m == MODE_CONFIG) && pos == 0) return ByteStart;
    if (m == MODE_CONFIG && pos == 1) return ByteLockA;
    return ByteZero;
  endfunction

  function automatic mode_e lock_next(mode_e m);
    case (m)
      MODE_SETUP:  return MODE_CONFIG;
      MODE_CONFIG: return MODE_EXIT;
      default:     return MODE_RUN;
    endcase
  endfunction

  // Advance the predicted sequencer by one exchange and return its result.
  function automatic poll_result_t step_sequencer(logic act, logic [ByteW-1:0] rx);
    poll_result_t r;
    logic [5:0]   want;
    r = '0;
    if (!act) begin
      poll_mode = link_mode;
      stage     = STG_CMD;
      body_pos  = '0;
      active    = 1'b1;
      r.tx      = ByteStart;
      r.send    = 1'b1;
    end else if (active) begin
      case (stage)
        STG_CMD: begin
          r.tx   = lock_cmd(poll_mode);
          r.send = 1'b1;
          stage  = STG_ID;
        end
        STG_ID: begin
          want        = {1'b0, rx[3:0], 1'b0};
          payload_len = (want > {1'b0, max_payload}) ? max_payload : want[PosW-1:0];
          if (poll_mode == MODE_RUN && rx[7:4] != analog_id) link_mode = MODE_SETUP;
          r.tx   = ByteZero;
          r.send = 1'b1;
          stage  = STG_ACK;
        end
        STG_ACK: begin
          body_pos = '0;
          if (rx != ByteAck) begin
            active = 1'b0;
          end else if (poll_mode == MODE_RUN) begin
            if (payload_len == '0) begin
              active = 1'b0;
            end else begin
              r.send = 1'b1;
              stage  = STG_BODY;
            end
          end else begin
            link_mode = lock_next(poll_mode);
            r.tx      = lock_tail(poll_mode, 0);
            r.send    = 1'b1;
            stage     = STG_BODY;
          end
        end
        default: begin
          if (poll_mode == MODE_RUN) begin
            r.dv   = 1'b1;
            r.idx  = body_pos;
            r.data = (body_pos < PosW'(2)) ? ~rx : rx;
            if (int'(body_pos) + 1 < int'(payload_len)) begin
              r.send   = 1'b1;
              body_pos = body_pos + PosW'(1);
            end else begin
              active = 1'b0;
            end
          end else if (int'(body_pos) + 1 < lock_tail_len(poll_mode)) begin
            r.tx     = lock_tail(poll_mode, int'(body_pos) + 1);
            r.send   = 1'b1;
            body_pos = body_pos + PosW'(1);
          end else begin
            active = 1'b0;
          end
        end
      endcase
    end
    r.mode = link_mode;
    return r;
  endfunction

  task automatic check_field(string name, logic [ByteW-1:0] want, logic [ByteW-1:0] got);
    if (got !== want) begin
      $error("%s: expected 0x%0h, actual 0x%0h", name, want, got);
      mismatches++;
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    poll_result_t e;
    if (!rst_ni) begin
      expected_results.delete();
      link_mode   = MODE_RUN;
      poll_mode   = MODE_RUN;
      stage       = STG_CMD;
      body_pos    = '0;
      payload_len = '0;
      max_payload = MaxPayloadRst;
      analog_id   = AnalogIdRst;
      active      = 1'b0;
      pending_o  <= 0;
    end else begin
      // Compare first: a result taken now always belongs to an earlier input.
      if (out_valid_i && out_ready_i) begin
        if (expected_results.size() == 0) begin
          $error("result transaction with nothing expected: tx_byte 0x%0h send %0b",
                 tx_byte_i, send_i);
          mismatches++;
        end else begin
          e = expected_results.pop_front();
          check_field("tx_byte", e.tx, tx_byte_i);
          check_field("send", 8'(e.send), 8'(send_i));
          check_field("data_valid", 8'(e.dv), 8'(data_valid_i));
          check_field("data_index", 8'(e.idx), 8'(data_index_i));
          check_field("data_byte", e.data, data_byte_i);
          check_field("mode_now", 8'(e.mode), 8'(mode_now_i));
        end
      end
      if (cfg_valid_i && cfg_ready_i) begin
        case (cfg_index_i)
          CFG_MAX_PAYLOAD: max_payload = cfg_data_i;
          CFG_ANALOG_ID:   analog_id   = cfg_data_i[IdW-1:0];
          default: ;
        endcase
      end
      if (in_valid_i && in_ready_i) begin
        expected_results.push_back(step_sequencer(action_i, rx_byte_i));
      end
      pending_o <= expected_results.size();
    end
  end

endmodule

FILE: tb/testbench.sv
// Testbench top: drives polls and register writes into the sequencer and reports the verdict.
module testbench;
  timeunit 1ns;
  timeprecision 1ps;
  import gpmls_pkg::*;

  // Cycles without any accepted transaction before the run is declared hung.
  localparam int unsigned StallLimit = 1000;
  // Random exchanges per register setting.
  localparam int unsigned PhaseItems = 100;

  logic                clk_i;
  logic                rst_ni      = 1'b0;
  logic                in_valid    = 1'b0;
  logic                in_ready;
  logic                action      = 1'b0;
  logic [ByteW-1:0]    rx_byte     = '0;
  logic                out_valid;
  logic                out_ready   = 1'b0;
  logic [ByteW-1:0]    tx_byte;
  logic                send;
  logic                data_valid;
  logic [PosW-1:0]     data_index;
  logic [ByteW-1:0]    data_byte;
  logic [ModeW-1:0]    mode_now;
  logic                cfg_valid   = 1'b0;
  logic                cfg_ready;
  logic [CfgIdxW-1:0]  cfg_index   = CFG_MAX_PAYLOAD;
  logic [CfgDataW-1:0] cfg_data    = '0;

  int unsigned         fail_count;
  int unsigned         pending;
  int unsigned         idle_cycles = 0;
  int unsigned         exchanges_sent = 0;

  // No random idling on either side while set.
  logic                quiet = 1'b0;

  // What the stimulus believes about the pad link, used only to shape polls
  // so that most of them run to their natural end.
  mode_e               pad_mode   = MODE_RUN;
  logic [PosW-1:0]     cur_max    = MaxPayloadRst;
  logic [IdW-1:0]      cur_analog = AnalogIdRst;

  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  gamepad_poll_and_mode_lock_sequencer i_dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid),
    .in_ready_o   (in_ready),
    .action_i     (action),
    .rx_byte_i    (rx_byte),
    .out_valid_o  (out_valid),
    .out_ready_i  (out_ready),
    .tx_byte_o    (tx_byte),
    .send_o       (send),
    .data_valid_o (data_valid),
    .data_index_o (data_index),
    .data_byte_o  (data_byte),
    .mode_now_o   (mode_now),
    .cfg_valid_i  (cfg_valid),
    .cfg_ready_o  (cfg_ready),
    .cfg_index_i  (cfg_index),
    .cfg_data_i   (cfg_data)
  );

  poll_exchange_checker i_checker (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid),
    .in_ready_i   (in_ready),
    .action_i     (action),
    .rx_byte_i    (rx_byte),
    .out_valid_i  (out_valid),
    .out_ready_i  (out_ready),
    .tx_byte_i    (tx_byte),
    .send_i       (send),
    .data_valid_i (data_valid),
    .data_index_i (data_index),
    .data_byte_i  (data_byte),
    .mode_now_i   (mode_now),
    .cfg_valid_i  (cfg_valid),
    .cfg_ready_i  (cfg_ready),
    .cfg_index_i  (cfg_index),
    .cfg_data_i   (cfg_data),
    .fail_count_o (fail_count),
    .pending_o    (pending)
  );

  // Receiver: stall in about 12 percent of cycles unless the quiet stretch is on.
  always @(posedge clk_i) begin
    out_ready <= quiet || ($urandom_range(0, 99) >= 12);
  end

  // Watchdog: count cycles in which no channel moves a transaction.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready)) begin
        idle_cycles <= 0;
      end else if (idle_cycles >= StallLimit) begin
        $display("CHECK FAILED");
        $finish;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
    end
  end

  // Present one exchange and hold it until the block takes it. Valid is left
  // high on return; the next call either changes the payload or drops it.
  task automatic exchange(input logic act, input logic [ByteW-1:0] rx);
    while (!quiet && $urandom_range(0, 99) < 12) begin
      in_valid <= 1'b0;
      @(posedge clk_i);
    end
    in_valid <= 1'b1;
    action   <= act;
    rx_byte  <= rx;
    @(posedge clk_i);
    while (!in_ready) @(posedge clk_i);
    exchanges_sent++;
  endtask

  // Drop the input and hold until every predicted result has been taken.
  // The first wait lets the count catch up with the transaction just accepted.
  task automatic wait_drained();
    in_valid <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
  endtask

  // Write both registers back to back once every predicted result has drained.
  task automatic program_regs(input logic [CfgDataW-1:0] maxp, input logic [IdW-1:0] aid);
    wait_drained();
    cfg_valid <= 1'b1;
    cfg_index <= CFG_MAX_PAYLOAD;
    cfg_data  <= maxp;
    @(posedge clk_i);
    while (!cfg_ready) @(posedge clk_i);
    cfg_index <= CFG_ANALOG_ID;
    cfg_data  <= CfgDataW'(aid) | CfgDataW'($urandom_range(0, 1) << IdW);
    @(posedge clk_i);
    while (!cfg_ready) @(posedge clk_i);
    cfg_valid  <= 1'b0;
    cur_max    = maxp;
    cur_analog = aid;
  endtask

  // Run one poll. Cut the poll short after 'cut' follow-up exchanges when it
  // is below 3 (a following start then abandons it); otherwise send the
  // header and as many body exchanges as the pad should need, adjusted by
  // body_delta (short bodies get abandoned, long ones add ignored bytes).
  task automatic run_poll(input logic [ByteW-1:0] id, input logic [ByteW-1:0] ack,
                          input int cut, input int body_delta);
    mode_e pm;
    int    body_n;
    pm = pad_mode;
    exchange(1'b0, ByteW'($urandom));
    if (cut == 0) return;
    exchange(1'b1, ByteW'($urandom));
    if (cut == 1) return;
    exchange(1'b1, id);
    if (pm == MODE_RUN && id[7:4] != cur_analog) pad_mode = MODE_SETUP;
    if (cut == 2) return;
    exchange(1'b1, ack);
    if (ack != ByteAck) begin
      body_n = 0;
    end else if (pm == MODE_RUN) begin
      body_n = 2 * int'(id[3:0]);
      if (body_n > int'(cur_max)) body_n = int'(cur_max);
    end else begin
      pad_mode = mode_e'(ModeW'(pm + 1));
      body_n   = (pm == MODE_SETUP) ? 2 : 6;
    end
    body_n = body_n + body_delta;
    for (int k = 0; k < body_n; k++) exchange(1'b1, ByteW'($urandom));
  endtask

  // Mostly well-formed polls with random content; the rest is broken polls
  // and stray bytes. About one ID in five has a foreign high nibble, which
  // walks the link through setup, configuring and exit setup.
  task automatic random_poll();
    logic [ByteW-1:0] id;
    logic [ByteW-1:0] ack;
    id[3:0] = IdW'($urandom);
    id[7:4] = ($urandom_range(0, 99) < 80) ? cur_analog : IdW'($urandom);
    ack     = ($urandom_range(0, 99) < 90) ? ByteAck : ByteW'($urandom);
    if ($urandom_range(0, 99) < 85) begin
      run_poll(id, ack, 3, 0);
    end else begin
      run_poll(id, ack, int'($urandom_range(0, 3)), int'($urandom_range(0, 4)) - 2);
    end
    if ($urandom_range(0, 99) < 4) exchange(1'b1, ByteW'($urandom));
  endtask

  initial begin
    logic [CfgDataW-1:0] phase_max [5];
    logic [IdW-1:0]      phase_id  [5];
    int unsigned         goal;
    phase_max = '{5'd30, 5'd0, 5'd31, 5'd13, 5'd6};
    phase_id  = '{4'd15, 4'd0, 4'd7, 4'd9, 4'd7};

    // Hold reset at the start, then release it on an edge.
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: a byte while idle, a full analog poll, a bad acknowledge,
    // a foreign ID with an empty payload, and a start during a poll.
    exchange(1'b1, 8'hFF);
    run_poll(8'h73, ByteAck, 3, 0);
    run_poll(8'h7F, 8'h00, 3, 0);
    run_poll(8'h00, ByteAck, 3, 0);
    run_poll(8'hFF, ByteAck, 2, 0);

    // Random phases, each under its own register setting. The third runs
    // with no idling on either side.
    for (int ph = 0; ph < 5; ph++) begin
      program_regs(phase_max[ph], phase_id[ph]);
      quiet <= (ph == 2);
      goal = exchanges_sent + PhaseItems;
      while (exchanges_sent < goal) begin
        random_poll();
        // Pause the sender now and then until everything has drained.
        if ($urandom_range(0, 99) < 3) wait_drained();
      end
    end

    // Drain, then keep clocking so the output register can show anything stray.
    quiet <= 1'b0;
    wait_drained();
    repeat (4) @(posedge clk_i);
    if (fail_count == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

FILE: files.f
hw/rtl/gpmls_pkg.sv
hw/rtl/gamepad_poll_and_mode_lock_sequencer.sv
tb/poll_exchange_checker.sv
tb/testbench.sv
